### rtl/core/wheel_speed_incremental_pid_core_defines.svh
// Assertion helpers shared by the wheel speed PID core.
`ifndef WHEEL_SPEED_INCREMENTAL_PID_CORE_DEFINES_SVH
`define WHEEL_SPEED_INCREMENTAL_PID_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WSPID_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define WSPID_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wspid_pkg.sv
package wspid_pkg;

    // Fixed field widths
    localparam int WHEEL_W   = 2;
    localparam int WHEEL_EXT = 5;
    localparam int SET_W     = 7;
    localparam int SCALE_W   = 16;
    localparam int COEF_W    = 20;
    localparam int DMAX_W    = 7;
    localparam int DRIVE_W   = 15;
    localparam int ERR_W     = 26;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = COEF_W + ERR_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int NEXT_W    = ACC_W - FRAC_W;
    localparam int CMP_W     = 40;
    localparam int ADDR_W    = 5;
    localparam int OUT_TDATA_W = 24;

    // Error saturation bounds, Q.8
    localparam logic signed [CMP_W-1:0] ERR_MAX = CMP_W'(33554431);
    localparam logic signed [CMP_W-1:0] ERR_MIN = -CMP_W'(33554432);

    // Half LSB of the Q.8 result in Q.24
    localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd512;
    localparam logic [COEF_W-1:0]  CUR_RST   = 20'd65798;
    localparam logic [COEF_W-1:0]  PREV_RST  = 20'hEFF7D;
    localparam logic [COEF_W-1:0]  OLD_RST   = 20'd131;
    localparam logic [DMAX_W-1:0]  DMAX_RST  = 7'd80;

    typedef enum logic [2:0] {
        REG_SPEED_SCALE   = 3'd0,
        REG_COEF_CURRENT  = 3'd1,
        REG_COEF_PREVIOUS = 3'd2,
        REG_COEF_OLDER    = 3'd3,
        REG_DRIVE_MAX     = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPEED,
        ST_ERR,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_OUT
    } fsm_t;

    typedef enum logic [1:0] {
        MUL_PREV,
        MUL_CUR,
        MUL_OLD
    } mul_sel_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [COEF_W-1:0]  coef_cur;
        logic [COEF_W-1:0]  coef_prev;
        logic [COEF_W-1:0]  coef_old;
        logic [DMAX_W-1:0]  drive_max;
    } cfg_t;

    // One wheel's stored state
    typedef struct packed {
        logic [ERR_W-1:0]   err_last;
        logic [ERR_W-1:0]   err_before;
        logic [DRIVE_W-1:0] drive_last;
    } state_t;

    typedef struct packed {
        logic     take;
        logic     speed_en;
        logic     err_en;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     finish;
    } ctl_t;

endpackage

### rtl/core/wheel_speed_incremental_pid_core.sv
// Per-wheel incremental PID speed controller.
// Input stream (s_axis_*): one beat per ended control period, carrying the
// wheel channel, the encoder pulse count and the speed setpoint. The core
// returns one result beat (m_axis_*) per input beat, in order: the wheel, the
// new clamped drive (Q7.8) and a clamp flag in tuser.
// Error history and last drive of each wheel live in one state memory that
// is read on accept and written back when the result is issued.
// Sequence: for a valid wheel the speed product has its own multiplier,
// then one shared multiplier forms the three coefficient products in turn,
// and the core takes no new beat until the result is issued.
// A beat naming a wheel at or beyond WHEELS returns drive 0 and leaves
// the state alone.
// Reset clears the FSM, the output valid flag and the per-wheel valid bits,
// so every wheel starts with zero history and zero drive; registers return
// to their defaults. If the receiver stalls, the result waits in the output
// register; the core takes one more beat and holds the next result until
// the register frees up. Configuration goes through the APB port at byte address
// 4*index; write it only while no beat is in flight; the core does not check.
`include "wheel_speed_incremental_pid_core_defines.svh"

module wheel_speed_incremental_pid_core
    import wspid_pkg::*;
#(
    parameter int WHEELS     = 4,
    parameter int PULSE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // wheel[1:0], pulse_count[PULSE_BITS+1:2], set_speed[PULSE_BITS+8:PULSE_BITS+2]
    input  logic [((PULSE_BITS+9+7)/8)*8-1:0] s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // wheel_out[1:0], drive[16:2]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // clamped[0]
    output logic                   m_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    logic [SCALE_W-1:0]    scale_reg;
    logic [COEF_W-1:0]     coef_cur_reg;
    logic [COEF_W-1:0]     coef_prev_reg;
    logic [COEF_W-1:0]     coef_old_reg;
    logic [DMAX_W-1:0]     dmax_reg;
    cfg_t                  cfg;
    reg_idx_t              reg_idx;
    logic                  cfg_wr;

    logic [WHEEL_W-1:0]    in_wheel;
    logic [PULSE_BITS-1:0] in_pulse;
    logic [SET_W-1:0]      in_set;
    logic [WHEEL_EXT-1:0]  wheel_ext;
    logic                  wheel_ok;

    ctl_t                  ctl;
    logic                  out_free;
    state_t                ent;
    state_t                wr_ent;
    logic [WHEEL_W-1:0]    wheel_q;
    logic [WHEEL_EXT-1:0]  wheel_q_ext;
    logic                  wheel_q_ok;
    logic                  live_q;
    logic [DRIVE_W-1:0]    drive_new;
    logic                  clamp_new;
    logic                  mem_wr_en;

    logic                  out_valid_reg;
    logic [WHEEL_W-1:0]    wheel_out_reg;
    logic [DRIVE_W-1:0]    drive_out_reg;
    logic                  clamp_out_reg;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= SCALE_RST;
            coef_cur_reg  <= CUR_RST;
            coef_prev_reg <= PREV_RST;
            coef_old_reg  <= OLD_RST;
            dmax_reg      <= DMAX_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SPEED_SCALE:   scale_reg     <= pwdata[SCALE_W-1:0];
                REG_COEF_CURRENT:  coef_cur_reg  <= pwdata[COEF_W-1:0];
                REG_COEF_PREVIOUS: coef_prev_reg <= pwdata[COEF_W-1:0];
                REG_COEF_OLDER:    coef_old_reg  <= pwdata[COEF_W-1:0];
                REG_DRIVE_MAX:     dmax_reg      <= pwdata[DMAX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            REG_SPEED_SCALE:   prdata = 32'(scale_reg);
            REG_COEF_CURRENT:  prdata = 32'($signed(coef_cur_reg));
            REG_COEF_PREVIOUS: prdata = 32'($signed(coef_prev_reg));
            REG_COEF_OLDER:    prdata = 32'($signed(coef_old_reg));
            REG_DRIVE_MAX:     prdata = 32'(dmax_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        cfg.scale     = scale_reg;
        cfg.coef_cur  = coef_cur_reg;
        cfg.coef_prev = coef_prev_reg;
        cfg.coef_old  = coef_old_reg;
        cfg.drive_max = dmax_reg;
    end

    // Unpack the input beat
    assign in_wheel  = s_axis_tdata[WHEEL_W-1:0];
    assign in_pulse  = s_axis_tdata[PULSE_BITS+WHEEL_W-1:WHEEL_W];
    assign in_set    = s_axis_tdata[PULSE_BITS+WHEEL_W+SET_W-1:PULSE_BITS+WHEEL_W];
    assign wheel_ext = WHEEL_EXT'(in_wheel);
    assign wheel_ok  = wheel_ext < WHEEL_EXT'(WHEELS);

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign mem_wr_en = ctl.finish && live_q;

    wspid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .wheel_ok (wheel_ok),
        .out_free (out_free),
        .s_ready  (s_axis_tready),
        .ctl      (ctl)
    );

    wspid_state_mem #(
        .DEPTH (WHEELS),
        .AW    (AW)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (ctl.take),
        .rd_addr (wheel_ext[AW-1:0]),
        .rd_data (ent),
        .wr_en   (mem_wr_en),
        .wr_addr (wheel_q_ext[AW-1:0]),
        .wr_data (wr_ent)
    );

    wspid_datapath #(
        .PULSE_BITS (PULSE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .ctl       (ctl),
        .cfg       (cfg),
        .in_wheel  (in_wheel),
        .in_pulse  (in_pulse),
        .in_set    (in_set),
        .wheel_ok  (wheel_ok),
        .ent       (ent),
        .wheel_q   (wheel_q),
        .live_q    (live_q),
        .wr_ent    (wr_ent),
        .drive_new (drive_new),
        .clamp_new (clamp_new)
    );

    assign wheel_q_ext = WHEEL_EXT'(wheel_q);
    assign wheel_q_ok  = wheel_q_ext < WHEEL_EXT'(WHEELS);

    // Output register: hold the result until the receiver takes the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.finish) begin
            wheel_out_reg <= wheel_q;
            drive_out_reg <= live_q ? drive_new : '0;
            clamp_out_reg <= live_q && clamp_new;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({drive_out_reg, wheel_out_reg});
    assign m_axis_tuser  = clamp_out_reg;

    `WSPID_ASSERT_NEXT(a_one_in_flight, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input taken while an item is in flight")
    `WSPID_ASSERT_SAME(a_finish_room, aclk, aresetn,
        ctl.finish, !out_valid_reg || m_axis_tready,
        "result issued over a pending beat")
    `WSPID_ASSERT_SAME(a_write_live, aclk, aresetn,
        mem_wr_en, wheel_q_ok,
        "state written for a wheel out of range")

endmodule

### rtl/core/wspid_state_mem.sv
module wspid_state_mem
    import wspid_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output state_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  state_t        wr_data
);

    state_t             mem_reg [DEPTH];
    state_t             rd_q_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg <= mem_reg[rd_addr];
        end
    end

    // Track written entries; unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

### rtl/core/wspid_ctrl.sv
module wspid_ctrl
    import wspid_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic wheel_ok,
    input  logic out_free,
    output logic s_ready,
    output ctl_t ctl
);

    fsm_t st_reg;
    fsm_t st_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // Sequence one item through the shared multiplier
    always_comb begin
        st_next     = st_reg;
        ctl         = '0;
        ctl.mul_sel = MUL_PREV;
        s_ready     = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.take = 1'b1;
                    st_next  = wheel_ok ? ST_SPEED : ST_OUT;
                end
            end
            ST_SPEED: begin
                ctl.speed_en = 1'b1;
                st_next      = ST_ERR;
            end
            ST_ERR: begin
                ctl.err_en  = 1'b1;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_PREV;
                st_next     = ST_P0;
            end
            ST_P0: begin
                ctl.mul_en   = 1'b1;
                ctl.mul_sel  = MUL_CUR;
                ctl.acc_load = 1'b1;
                st_next      = ST_P1;
            end
            ST_P1: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_OLD;
                ctl.acc_add = 1'b1;
                st_next     = ST_P2;
            end
            ST_P2: begin
                ctl.acc_add = 1'b1;
                st_next     = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    ctl.finish = 1'b1;
                    st_next    = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/wspid_datapath.sv
module wspid_datapath
    import wspid_pkg::*;
#(
    parameter int PULSE_BITS = 12
) (
    input  logic                  aclk,
    input  ctl_t                  ctl,
    input  cfg_t                  cfg,
    input  logic [WHEEL_W-1:0]    in_wheel,
    input  logic [PULSE_BITS-1:0] in_pulse,
    input  logic [SET_W-1:0]      in_set,
    input  logic                  wheel_ok,
    input  state_t                ent,
    output logic [WHEEL_W-1:0]    wheel_q,
    output logic                  live_q,
    output state_t                wr_ent,
    output logic [DRIVE_W-1:0]    drive_new,
    output logic                  clamp_new
);

    localparam int SPEED_W = PULSE_BITS + SCALE_W;

    logic [WHEEL_W-1:0]       wheel_reg;
    logic                     live_reg;
    logic [PULSE_BITS-1:0]    pulse_reg;
    logic [SET_W-1:0]         set_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic [SPEED_W-1:0]       speed_next;
    logic [ERR_W-1:0]         err_reg;
    logic [ERR_W-1:0]         err_next;
    logic signed [CMP_W-1:0]  diff;
    logic signed [COEF_W-1:0] coef_op;
    logic signed [ERR_W-1:0]  err_op;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [NEXT_W-1:0] level;
    logic [DRIVE_W-1:0]       top;

    // Measured speed, Q.8
    assign speed_next = SPEED_W'(pulse_reg) * SPEED_W'(cfg.scale);

    // Error with saturation to the stored width
    always_comb begin
        diff = $signed(CMP_W'({set_reg, 8'h00})) - $signed(CMP_W'(speed_reg));
        if (diff > ERR_MAX) begin
            err_next = ERR_MAX[ERR_W-1:0];
        end else if (diff < ERR_MIN) begin
            err_next = ERR_MIN[ERR_W-1:0];
        end else begin
            err_next = diff[ERR_W-1:0];
        end
    end

    // Select operands of the shared multiplier
    always_comb begin
        case (ctl.mul_sel)
            MUL_CUR: begin
                coef_op = $signed(cfg.coef_cur);
                err_op  = $signed(err_reg);
            end
            MUL_OLD: begin
                coef_op = $signed(cfg.coef_old);
                err_op  = $signed(ent.err_before);
            end
            default: begin
                coef_op = $signed(cfg.coef_prev);
                err_op  = $signed(ent.err_last);
            end
        endcase
        prod_next = PROD_W'(coef_op) * PROD_W'(err_op);
    end

    // Accumulate in Q.24, seeded with last drive and the rounding half
    always_comb begin
        if (ctl.acc_load) begin
            acc_next = ACC_W'(prod_reg)
                     + $signed(ACC_W'({ent.drive_last, ROUND_HALF}));
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            wheel_reg <= in_wheel;
            live_reg  <= wheel_ok;
            pulse_reg <= in_pulse;
            set_reg   <= in_set;
        end
        if (ctl.speed_en) begin
            speed_reg <= speed_next;
        end
        if (ctl.err_en) begin
            err_reg <= err_next;
        end
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctl.acc_load || ctl.acc_add) begin
            acc_reg <= acc_next;
        end
    end

    // Clamp the new drive to 0..drive_max
    always_comb begin
        level     = acc_reg[ACC_W-1:FRAC_W];
        top       = DRIVE_W'({cfg.drive_max, 8'h00});
        drive_new = level[DRIVE_W-1:0];
        clamp_new = 1'b0;
        if (level < 0) begin
            drive_new = '0;
            clamp_new = 1'b1;
        end else if (level > $signed(NEXT_W'(top))) begin
            drive_new = top;
            clamp_new = 1'b1;
        end
    end

    // Shift the error history and store the new drive
    always_comb begin
        wr_ent.err_last   = err_reg;
        wr_ent.err_before = ent.err_last;
        wr_ent.drive_last = drive_new;
    end

    assign wheel_q = wheel_reg;
    assign live_q  = live_reg;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wspid_pkg::*;

    localparam int PULSE_BITS = 12;
    localparam int IN_W       = ((PULSE_BITS + 9 + 7) / 8) * 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int PLAN_LEN   = 26;
    localparam int PHASE_BEATS = 200;

    // One expected result beat
    typedef struct {
        logic [WHEEL_W-1:0] wheel;
        logic [DRIVE_W-1:0] drive;
        logic               clamped;
    } drive_beat_t;

    // One row of the directed plan: either a register write or a period beat
    typedef struct {
        logic               is_write;
        reg_idx_t           idx;
        int                 value;
        logic [WHEEL_W-1:0] wheel;
        logic [11:0]        pulses;
        logic [SET_W-1:0]   set_speed;
        logic               known;
        logic [DRIVE_W-1:0] drive;
        logic               clamped;
    } plan_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow copy of the registers
    logic [SCALE_W-1:0]       scale_q   = 16'd512;
    logic signed [COEF_W-1:0] gain_cur  = 20'sd65798;
    logic signed [COEF_W-1:0] gain_prev = -20'sd65667;
    logic signed [COEF_W-1:0] gain_old  = 20'sd131;
    logic [DMAX_W-1:0]        top_units = 7'd80;

    // Per-wheel controller history
    longint err_prev  [4];
    longint err_prev2 [4];
    longint drive_hist[4];

    drive_beat_t pending_drives[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    plan_row_t plan [PLAN_LEN] = '{
        '{1'b0, REG_SPEED_SCALE, 0, 2'd0, 12'd0,    7'd0,   1'b1, 15'd0,     1'b0},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd1, 12'd0,    7'd100, 1'b1, 15'd20480, 1'b1},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd2, 12'd4095, 7'd0,   1'b1, 15'd0,     1'b1},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd3, 12'd4095, 7'd100, 1'b1, 15'd0,     1'b1},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd0, 12'd1,    7'd1,   1'b0, 15'd0,     1'b0},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd1, 12'd40,   7'd80,  1'b0, 15'd0,     1'b0},
        '{1'b1, REG_COEF_CURRENT,  65536, 2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b1, REG_COEF_PREVIOUS, 0,     2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b1, REG_COEF_OLDER,    0,     2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b1, REG_SPEED_SCALE,   0,     2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b1, REG_DRIVE_MAX,     100,   2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        // drive lands exactly on the upper clamp: not flagged
        '{1'b0, REG_SPEED_SCALE, 0, 2'd0, 12'd123,  7'd100, 1'b1, 15'd25600, 1'b0},
        // drive lands exactly on zero: not flagged
        '{1'b0, REG_SPEED_SCALE, 0, 2'd2, 12'd0,    7'd0,   1'b1, 15'd0,     1'b0},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd0, 12'd4095, 7'd0,   1'b0, 15'd0,     1'b0},
        '{1'b1, REG_DRIVE_MAX,     0,     2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd1, 12'd7,    7'd3,   1'b0, 15'd0,     1'b0},
        '{1'b1, REG_SPEED_SCALE,   65535,   2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b1, REG_COEF_CURRENT,  524287,  2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b1, REG_COEF_PREVIOUS, -524288, 2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b1, REG_COEF_OLDER,    524287,  2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        '{1'b1, REG_DRIVE_MAX,     100,     2'd0, 12'd0, 7'd0, 1'b0, 15'd0, 1'b0},
        // error far past the 26-bit range: saturates
        '{1'b0, REG_SPEED_SCALE, 0, 2'd3, 12'd4095, 7'd0,   1'b0, 15'd0,     1'b0},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd3, 12'd4095, 7'd100, 1'b0, 15'd0,     1'b0},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd3, 12'd0,    7'd100, 1'b0, 15'd0,     1'b0},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd1, 12'd2048, 7'd64,  1'b0, 15'd0,     1'b0},
        '{1'b0, REG_SPEED_SCALE, 0, 2'd2, 12'd2730, 7'd27,  1'b0, 15'd0,     1'b0}
    };

    wheel_speed_incremental_pid_core #(
        .WHEELS     (4),
        .PULSE_BITS (PULSE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Advance one wheel's controller by one period and return its drive beat
    function automatic drive_beat_t pid_update(input logic [WHEEL_W-1:0] w,
                                              input logic [11:0] pulses,
                                              input logic [SET_W-1:0] set_speed);
        longint err;
        longint acc;
        longint nxt;
        longint ceiling;
        drive_beat_t beat;
        beat.wheel = w;
        beat.clamped = 1'b0;
        err = longint'(set_speed) * 256 - longint'(pulses) * longint'(scale_q);
        if (err < -longint'(33554432)) err = -longint'(33554432);
        if (err > longint'(33554431)) err = longint'(33554431);
        acc = longint'(gain_cur) * err + longint'(gain_prev) * err_prev[w]
            + longint'(gain_old) * err_prev2[w];
        // round half up to Q.8; arithmetic shift floors
        nxt = drive_hist[w] + ((acc + 32768) >>> 16);
        ceiling = longint'(top_units) * 256;
        if (nxt < 0) begin
            nxt = 0;
            beat.clamped = 1'b1;
        end else if (nxt > ceiling) begin
            nxt = ceiling;
            beat.clamped = 1'b1;
        end
        beat.drive = DRIVE_W'(nxt);
        err_prev2[w] = err_prev[w];
        err_prev[w] = err;
        drive_hist[w] = nxt;
        return beat;
    endfunction

    // Offer one period beat, wait for accept, record what it should produce
    task automatic send_period(input logic [WHEEL_W-1:0] w, input logic [11:0] pulses,
                               input logic [SET_W-1:0] set_speed, input logic known,
                               input logic [DRIVE_W-1:0] drive, input logic clamped);
        drive_beat_t beat;
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata  <= IN_W'({set_speed, pulses, w});
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        beat = pid_update(w, pulses, set_speed);
        if (known) begin
            beat.drive = drive;
            beat.clamped = clamped;
        end
        pending_drives.push_back(beat);
    endtask

    // Drop valid and wait for every result plus the core's latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input reg_idx_t idx, input int value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SPEED_SCALE:   scale_q   = value[15:0];
            REG_COEF_CURRENT:  gain_cur  = value[19:0];
            REG_COEF_PREVIOUS: gain_prev = value[19:0];
            REG_COEF_OLDER:    gain_old  = value[19:0];
            REG_DRIVE_MAX:     top_units = value[6:0];
            default: ;
        endcase
    endtask

    // Mostly periods near the setpoint, the rest anywhere in range
    task automatic random_period();
        logic [WHEEL_W-1:0] w;
        logic [SET_W-1:0]   set_speed;
        int                 pulses;
        w = WHEEL_W'($urandom_range(0, 3));
        set_speed = SET_W'($urandom_range(0, 100));
        if (scale_q != 0 && $urandom_range(0, 99) < 75) begin
            pulses = (int'(set_speed) * 256) / int'(scale_q)
                   + int'($urandom_range(0, 6)) - 3;
            if (pulses < 0) pulses = 0;
            if (pulses > 4095) pulses = 4095;
        end else begin
            pulses = int'($urandom_range(0, 4095));
        end
        send_period(w, 12'(pulses), set_speed, 1'b0, '0, 1'b0);
    endtask

    // Receiver stalls at random, except during the steady stretch
    always @(posedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        drive_beat_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_drives.size() == 0) begin
                flag_mismatch("result beat with nothing pending");
            end else begin
                want = pending_drives.pop_front();
                if (m_axis_tdata[1:0] != want.wheel)
                    flag_mismatch($sformatf("wheel %0d, want %0d",
                                            m_axis_tdata[1:0], want.wheel));
                if (m_axis_tdata[16:2] != want.drive)
                    flag_mismatch($sformatf("wheel %0d drive %0d, want %0d", want.wheel,
                                            m_axis_tdata[16:2], want.drive));
                if (m_axis_tuser != want.clamped)
                    flag_mismatch($sformatf("wheel %0d clamp flag %0b, want %0b",
                                            want.wheel, m_axis_tuser, want.clamped));
            end
        end
    end

    // Main sequence
    initial begin
        int scale_v;
        int cur_v;
        int prev_v;
        int old_v;
        int top_v;
        for (int i = 0; i < 4; i++) begin
            err_prev[i] = 0;
            err_prev2[i] = 0;
            drive_hist[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed plan
        foreach (plan[i]) begin
            if (plan[i].is_write)
                write_reg(plan[i].idx, plan[i].value);
            else
                send_period(plan[i].wheel, plan[i].pulses, plan[i].set_speed,
                            plan[i].known, plan[i].drive, plan[i].clamped);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    scale_v = 512; cur_v = 65798; prev_v = -65667; old_v = 131; top_v = 80;
                end
                1: begin
                    scale_v = 65535; cur_v = 524287; prev_v = 524287; old_v = 524287;
                    top_v = 100;
                end
                2: begin
                    scale_v = 0; cur_v = -524288; prev_v = -524288; old_v = -524288;
                    top_v = 0;
                end
                3, 6: begin
                    scale_v = int'($urandom_range(256, 1024));
                    cur_v   = int'($urandom_range(60000, 70000));
                    prev_v  = -int'($urandom_range(60000, 70000));
                    old_v   = int'($urandom_range(0, 4000)) - 2000;
                    top_v   = int'($urandom_range(20, 100));
                end
                default: begin
                    scale_v = int'($urandom_range(0, 65535));
                    cur_v   = int'($urandom_range(0, 1048575)) - 524288;
                    prev_v  = int'($urandom_range(0, 1048575)) - 524288;
                    old_v   = int'($urandom_range(0, 1048575)) - 524288;
                    top_v   = int'($urandom_range(0, 100));
                end
            endcase
            write_reg(REG_SPEED_SCALE, scale_v);
            write_reg(REG_COEF_CURRENT, cur_v);
            write_reg(REG_COEF_PREVIOUS, prev_v);
            write_reg(REG_COEF_OLDER, old_v);
            write_reg(REG_DRIVE_MAX, top_v);
            steady = (ph == 3);
            repeat (PHASE_BEATS) random_period();
        end

        steady = 1'b0;
        drain();
        if (pending_drives.size() != 0)
            flag_mismatch("expected results left over");
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
